/* design/z85_pkg.sv */
// ----------------------------------------------------------------------------
// z85_pkg
// shared types, constants and alphabet functions of the z85 stream codec
// ----------------------------------------------------------------------------
package z85_pkg;

  // number of characters in one encoded group and bytes in one decoded group
  localparam int unsigned NumChars   = 5;
  localparam int unsigned NumBytes   = 4;
  localparam int unsigned MaxResults = 5;
  localparam int unsigned IdxW       = $clog2(MaxResults);

  // default depth of the job queue between front and back
  localparam int unsigned JobFifoDepth = 2;

  // floor(v / 85) == (v * RecipMul) >> RecipShift for every 32-bit v
  localparam logic [31:0] RecipMul   = 32'd3233857729;
  localparam int unsigned RecipShift = 38;
  localparam int unsigned QuoW       = 26;

  typedef enum logic [1:0] {
    STATUS_OK       = 2'd0,
    STATUS_BAD_CHAR = 2'd1,
    STATUS_OVERFLOW = 2'd2,
    STATUS_SHORT    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    JOB_ENCODE = 2'd0,
    JOB_DECODE = 2'd1,
    JOB_ERROR  = 2'd2
  } job_kind_e;

  typedef struct packed {
    job_kind_e   kind;
    logic [31:0] data;
    logic        last_item;
    status_e     status;
  } job_t;

  typedef struct packed {
    logic       valid;
    logic [6:0] digit;
  } digit_t;

  // base-85 digit to alphabet character
  function automatic logic [7:0] z85_char(input logic [6:0] d);
    logic [7:0] c;
    c = 8'h00;
    if (d < 7'd10) begin
      c = 8'h30 + {1'b0, d};
    end else if (d < 7'd36) begin
      c = 8'h57 + {1'b0, d};
    end else if (d < 7'd62) begin
      c = 8'h1D + {1'b0, d};
    end else begin
      unique case (d)
        7'd62:   c = 8'h2E;
        7'd63:   c = 8'h2D;
        7'd64:   c = 8'h3A;
        7'd65:   c = 8'h2B;
        7'd66:   c = 8'h3D;
        7'd67:   c = 8'h5E;
        7'd68:   c = 8'h21;
        7'd69:   c = 8'h2F;
        7'd70:   c = 8'h2A;
        7'd71:   c = 8'h3F;
        7'd72:   c = 8'h26;
        7'd73:   c = 8'h3C;
        7'd74:   c = 8'h3E;
        7'd75:   c = 8'h28;
        7'd76:   c = 8'h29;
        7'd77:   c = 8'h5B;
        7'd78:   c = 8'h5D;
        7'd79:   c = 8'h7B;
        7'd80:   c = 8'h7D;
        7'd81:   c = 8'h40;
        7'd82:   c = 8'h25;
        7'd83:   c = 8'h24;
        7'd84:   c = 8'h23;
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // alphabet character to base-85 digit, valid low for codes outside the alphabet
  function automatic digit_t z85_digit(input logic [7:0] code);
    digit_t r;
    r.valid = 1'b1;
    r.digit = 7'd0;
    if (code >= 8'h30 && code <= 8'h39) begin
      r.digit = 7'(code - 8'h30);
    end else if (code >= 8'h61 && code <= 8'h7A) begin
      r.digit = 7'(code - 8'h57);
    end else if (code >= 8'h41 && code <= 8'h5A) begin
      r.digit = 7'(code - 8'h1D);
    end else begin
      unique case (code)
        8'h2E:   r.digit = 7'd62;
        8'h2D:   r.digit = 7'd63;
        8'h3A:   r.digit = 7'd64;
        8'h2B:   r.digit = 7'd65;
        8'h3D:   r.digit = 7'd66;
        8'h5E:   r.digit = 7'd67;
        8'h21:   r.digit = 7'd68;
        8'h2F:   r.digit = 7'd69;
        8'h2A:   r.digit = 7'd70;
        8'h3F:   r.digit = 7'd71;
        8'h26:   r.digit = 7'd72;
        8'h3C:   r.digit = 7'd73;
        8'h3E:   r.digit = 7'd74;
        8'h28:   r.digit = 7'd75;
        8'h29:   r.digit = 7'd76;
        8'h5B:   r.digit = 7'd77;
        8'h5D:   r.digit = 7'd78;
        8'h7B:   r.digit = 7'd79;
        8'h7D:   r.digit = 7'd80;
        8'h40:   r.digit = 7'd81;
        8'h25:   r.digit = 7'd82;
        8'h24:   r.digit = 7'd83;
        8'h23:   r.digit = 7'd84;
        default: r.valid = 1'b0;
      endcase
    end
    return r;
  endfunction

endpackage

/* design/z85_front.sv */
// ----------------------------------------------------------------------------
// z85_front
// accepts words, gathers groups, detects errors and issues jobs to the back
// ----------------------------------------------------------------------------
module z85_front (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic            cfg_wdata_i,
  input  logic            accept_i,
  input  logic [7:0]      in_value_i,
  input  logic            end_of_input_i,
  output logic            job_push_o,
  output z85_pkg::job_t   job_o
);

  logic        dir_q, dir_d;
  logic [32:0] acc_q, acc_d;
  logic [2:0]  cnt_q, cnt_d;
  logic        hold_q, hold_d;

  z85_pkg::digit_t dig;
  logic [32:0]     enc_acc;
  logic [39:0]     dec_sum;
  logic [32:0]     dec_acc;
  logic [2:0]      cnt_inc;

  assign dig     = z85_pkg::z85_digit(in_value_i);
  assign enc_acc = {acc_q[24:0], in_value_i};
  // acc * 85 + digit
  assign dec_sum = {1'b0, acc_q, 6'b0} + {3'b0, acc_q, 4'b0} + {5'b0, acc_q, 2'b0}
                 + {7'b0, acc_q} + {33'b0, dig.digit};
  assign dec_acc = dec_sum[32:0];
  assign cnt_inc = cnt_q + 3'd1;

  always_comb begin
    dir_d            = dir_q;
    acc_d            = acc_q;
    cnt_d            = cnt_q;
    hold_d           = hold_q;
    job_push_o       = 1'b0;
    job_o.kind       = z85_pkg::JOB_ERROR;
    job_o.data       = enc_acc[31:0];
    job_o.last_item  = end_of_input_i;
    job_o.status     = z85_pkg::STATUS_OK;

    if (cfg_we_i) begin
      dir_d  = cfg_wdata_i;
      acc_d  = '0;
      cnt_d  = '0;
      hold_d = 1'b0;
    end else if (accept_i) begin
      if (hold_q) begin
        // dropping until end of stream
        if (end_of_input_i) begin
          hold_d = 1'b0;
        end
      end else if (!dir_q) begin
        if (cnt_inc == 3'(z85_pkg::NumBytes)) begin
          job_push_o = 1'b1;
          job_o.kind = z85_pkg::JOB_ENCODE;
          acc_d      = '0;
          cnt_d      = '0;
        end else if (end_of_input_i) begin
          job_push_o   = 1'b1;
          job_o.status = z85_pkg::STATUS_SHORT;
          acc_d        = '0;
          cnt_d        = '0;
        end else begin
          acc_d = enc_acc;
          cnt_d = cnt_inc;
        end
      end else begin
        job_o.data = dec_acc[31:0];
        if (!dig.valid) begin
          job_push_o   = 1'b1;
          job_o.status = z85_pkg::STATUS_BAD_CHAR;
          acc_d        = '0;
          cnt_d        = '0;
          hold_d       = !end_of_input_i;
        end else if (cnt_inc == 3'(z85_pkg::NumChars)) begin
          job_push_o = 1'b1;
          acc_d      = '0;
          cnt_d      = '0;
          if (dec_acc[32]) begin
            job_o.status = z85_pkg::STATUS_OVERFLOW;
            hold_d       = !end_of_input_i;
          end else begin
            job_o.kind = z85_pkg::JOB_DECODE;
          end
        end else if (end_of_input_i) begin
          job_push_o   = 1'b1;
          job_o.status = z85_pkg::STATUS_SHORT;
          acc_d        = '0;
          cnt_d        = '0;
        end else begin
          acc_d = dec_acc;
          cnt_d = cnt_inc;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q  <= 1'b0;
      acc_q  <= '0;
      cnt_q  <= '0;
      hold_q <= 1'b0;
    end else begin
      dir_q  <= dir_d;
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      hold_q <= hold_d;
    end
  end

endmodule

/* design/z85_job_fifo.sv */
// ----------------------------------------------------------------------------
// z85_job_fifo
// short queue of jobs between front and back
// ----------------------------------------------------------------------------
module z85_job_fifo #(
  parameter int unsigned Depth = z85_pkg::JobFifoDepth
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  z85_pkg::job_t wdata_i,
  output logic          full_o,
  input  logic          pop_i,
  output z85_pkg::job_t rdata_o,
  output logic          empty_o
);

  localparam int unsigned PtrW = $clog2(Depth);
  localparam int unsigned CntW = $clog2(Depth + 1);

  z85_pkg::job_t mem_q [Depth];
  logic [PtrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign full_o  = (count_q == CntW'(Depth));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      if (do_push) begin
        wptr_q <= wrap_inc(wptr_q);
      end
      if (do_pop) begin
        rptr_q <= wrap_inc(rptr_q);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

endmodule

/* design/z85_back.sv */
// ----------------------------------------------------------------------------
// z85_back
// carries out jobs: base-85 conversion, byte split and result delivery
// ----------------------------------------------------------------------------
module z85_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_empty_i,
  input  z85_pkg::job_t job_i,
  output logic          job_pop_o,
  input  logic          pop_i,
  output logic          empty_o,
  output logic [7:0]    out_value_o,
  output logic          run_last_o,
  output logic          stream_end_o,
  output logic [1:0]    status_o
);

  localparam int unsigned IdxW = z85_pkg::IdxW;
  localparam int unsigned QuoW = z85_pkg::QuoW;

  typedef enum logic [2:0] {
    CV_IDLE   = 3'b001,
    CV_DIVIDE = 3'b010,
    CV_READY  = 3'b100
  } conv_state_e;

  conv_state_e state_q, state_d;

  // divider loop
  logic [IdxW-1:0] cnt_q;
  logic [31:0]     val_q;
  logic            r_valid_q;
  logic [31:0]     r_num_q;
  logic [QuoW-1:0] r_quo_q;
  logic [IdxW-1:0] r_pos_q;

  // prepared burst
  logic [7:0]       conv_bytes_q [z85_pkg::MaxResults];
  logic [IdxW-1:0]  conv_last_q;
  logic             conv_end_q;
  z85_pkg::status_e conv_status_q;

  // burst being delivered
  logic             emit_valid_q;
  logic [7:0]       emit_bytes_q [z85_pkg::MaxResults];
  logic [IdxW-1:0]  emit_idx_q;
  logic [IdxW-1:0]  emit_last_q;
  logic             emit_end_q;
  z85_pkg::status_e emit_status_q;

  logic [63:0]     prod;
  logic [QuoW-1:0] quo;
  logic [31:0]     rem_full;
  logic [6:0]      digit;
  logic            issue, last_digit, burst_done, burst_free, load;

  assign prod     = 64'(val_q) * 64'(z85_pkg::RecipMul);
  assign quo      = QuoW'(prod >> z85_pkg::RecipShift);
  assign rem_full = r_num_q - (32'(r_quo_q) * 32'd85);
  assign digit    = rem_full[6:0];

  assign job_pop_o  = (state_q == CV_IDLE) && !job_empty_i;
  assign issue      = (state_q == CV_DIVIDE) && (cnt_q != IdxW'(z85_pkg::NumChars));
  assign last_digit = r_valid_q && (r_pos_q == '0);
  assign burst_done = pop_i && emit_valid_q && (emit_idx_q == emit_last_q);
  assign burst_free = !emit_valid_q || burst_done;
  assign load       = (state_q == CV_READY) && burst_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      CV_IDLE: begin
        if (job_pop_o) begin
          state_d = (job_i.kind == z85_pkg::JOB_ENCODE) ? CV_DIVIDE : CV_READY;
        end
      end
      CV_DIVIDE: begin
        if (last_digit) begin
          state_d = CV_READY;
        end
      end
      CV_READY: begin
        if (load) begin
          state_d = CV_IDLE;
        end
      end
      default: state_d = CV_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= CV_IDLE;
      cnt_q        <= '0;
      r_valid_q    <= 1'b0;
      emit_valid_q <= 1'b0;
      emit_idx_q   <= '0;
    end else begin
      state_q <= state_d;
      if (job_pop_o) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + IdxW'(1);
      end
      r_valid_q <= issue;
      if (load) begin
        emit_valid_q <= 1'b1;
        emit_idx_q   <= '0;
      end else if (burst_done) begin
        emit_valid_q <= 1'b0;
      end else if (pop_i && emit_valid_q) begin
        emit_idx_q <= emit_idx_q + IdxW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      val_q         <= job_i.data;
      conv_end_q    <= job_i.last_item;
      conv_status_q <= job_i.status;
      unique case (job_i.kind)
        z85_pkg::JOB_ENCODE: begin
          conv_last_q <= IdxW'(z85_pkg::NumChars - 1);
        end
        z85_pkg::JOB_DECODE: begin
          conv_last_q     <= IdxW'(z85_pkg::NumBytes - 1);
          conv_bytes_q[0] <= job_i.data[31:24];
          conv_bytes_q[1] <= job_i.data[23:16];
          conv_bytes_q[2] <= job_i.data[15:8];
          conv_bytes_q[3] <= job_i.data[7:0];
        end
        default: begin
          conv_last_q     <= '0;
          conv_bytes_q[0] <= 8'h00;
        end
      endcase
    end
    if (issue) begin
      val_q   <= {{(32 - QuoW){1'b0}}, quo};
      r_num_q <= val_q;
      r_quo_q <= quo;
      // least significant digit comes out first
      r_pos_q <= IdxW'(z85_pkg::NumChars - 1) - cnt_q;
    end
    if (r_valid_q) begin
      conv_bytes_q[r_pos_q] <= z85_pkg::z85_char(digit);
    end
    if (load) begin
      emit_bytes_q  <= conv_bytes_q;
      emit_last_q   <= conv_last_q;
      emit_end_q    <= conv_end_q;
      emit_status_q <= conv_status_q;
    end
  end

  assign empty_o      = !emit_valid_q;
  assign out_value_o  = emit_bytes_q[emit_idx_q];
  assign run_last_o   = (emit_idx_q == emit_last_q);
  assign stream_end_o = emit_end_q;
  assign status_o     = emit_status_q;

endmodule

/* design/z85_stream_codec.sv */
// ----------------------------------------------------------------------------
// z85_stream_codec
// streaming z85 encoder and decoder with queue-style ports on both sides
// ----------------------------------------------------------------------------
// In encode mode (direction 0) every four bytes give five alphabet characters,
// most significant digit first; in decode mode (direction 1) every five
// characters give four bytes, most significant first. A bad character, a
// group above 0xFFFFFFFF or a partial group at end_of_input gives a single
// error word with out_value zero, after which words are dropped until the end
// of the stream. Writing direction starts a new stream. Rate: a decode word
// is taken every cycle while the job queue has room, and four result words
// leave per group at one per cycle while pop is held. In the back an encode
// group is fetched from the job queue, runs through the divide-by-85 loop,
// which produces one digit per cycle through a 32x32 reciprocal multiplier
// and a remainder stage, and is then handed as a burst to the output register
// once that register is free; only then is the next job fetched. Every result
// passes through the job queue, the prepared-burst and the output registers.
// ----------------------------------------------------------------------------
module z85_stream_codec #(
  parameter int unsigned JobDepth = z85_pkg::JobFifoDepth // 2 or more
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // configuration
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  // input queue side
  input  logic       push_i,
  output logic       full_o,
  input  logic [7:0] in_value_i,
  input  logic       end_of_input_i,
  // result queue side
  output logic       empty_o,
  input  logic       pop_i,
  output logic [7:0] out_value_o,
  output logic       run_last_o,
  output logic       stream_end_o,
  output logic [1:0] status_o
);

  logic          accept;
  logic          job_push;
  z85_pkg::job_t job_in;
  logic          job_pop;
  z85_pkg::job_t job_out;
  logic          job_empty;
  logic          job_full;

  // a word is taken whenever the job queue has room, even if it makes no job
  assign full_o = job_full;
  assign accept = push_i && !job_full;

  // front: grouping, alphabet lookup, error tracking
  z85_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .accept_i      (accept),
    .in_value_i    (in_value_i),
    .end_of_input_i(end_of_input_i),
    .job_push_o    (job_push),
    .job_o         (job_in)
  );

  // decoupling queue, one job per finished group or error
  z85_job_fifo #(
    .Depth(JobDepth)
  ) u_job_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (job_push),
    .wdata_i(job_in),
    .full_o (job_full),
    .pop_i  (job_pop),
    .rdata_o(job_out),
    .empty_o(job_empty)
  );

  // back: base-85 conversion and result delivery
  z85_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_empty_i (job_empty),
    .job_i       (job_out),
    .job_pop_o   (job_pop),
    .pop_i       (pop_i),
    .empty_o     (empty_o),
    .out_value_o (out_value_o),
    .run_last_o  (run_last_o),
    .stream_end_o(stream_end_o),
    .status_o    (status_o)
  );

endmodule
